@@ src/fixed_point_16_16_divider_core_assert.svh @@
// Assertion macros shared by the divider checker.
`ifndef FIXED_POINT_16_16_DIVIDER_CORE_ASSERT_SVH
`define FIXED_POINT_16_16_DIVIDER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FPD_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("fpd assertion failed");

// Implication with a sequence consequent (delays allowed in cons).
`define FPD_ASSERT_SEQ(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> cons) \
    else $error("fpd sequence assertion failed");

`endif

@@ src/fpd_pkg.sv @@
// Package for the fixed-point divider: widths, constants and stage type.
package fpd_pkg;

  localparam int unsigned WordW      = 32;
  localparam int unsigned FracBits   = 16;
  localparam int unsigned GuardShift = 30 - FracBits;
  localparam int unsigned QuotBits   = 30;
  localparam int unsigned NumW       = WordW + FracBits;
  localparam int unsigned Latency    = QuotBits + 2;

  localparam logic [WordW-1:0] MostNeg = {1'b1, {(WordW-1){1'b0}}};
  localparam logic [WordW-1:0] MostPos = {1'b0, {(WordW-1){1'b1}}};

  typedef struct packed {
    logic                valid;
    logic                sat;
    logic                neg;
    logic [WordW-1:0]    rem;
    logic [QuotBits-1:0] dq;   // dividend bits still to shift in, quotient bits shifted out
    logic [WordW-1:0]    den;
  } stage_t;

endpackage

@@ src/fpd_prep.sv @@
// Input stage: operand magnitudes, overflow test, first partial remainder.
module fpd_prep (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic signed [fpd_pkg::WordW-1:0] dividend_i,
  input  logic signed [fpd_pkg::WordW-1:0] divisor_i,
  output fpd_pkg::stage_t              stage_o
);

  logic [fpd_pkg::WordW-1:0] mnum, mden, rem0;
  logic [fpd_pkg::NumW-1:0]  num_ext;
  logic                      valid_q;
  fpd_pkg::stage_t           pay_q;

  assign mnum    = dividend_i[fpd_pkg::WordW-1] ? (~dividend_i + 1'b1) : dividend_i;
  assign mden    = divisor_i[fpd_pkg::WordW-1]  ? (~divisor_i + 1'b1)  : divisor_i;
  assign rem0    = mnum >> fpd_pkg::GuardShift;
  assign num_ext = {mnum, {fpd_pkg::FracBits{1'b0}}};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= start_i;
    end
  end

  always_ff @(posedge clk_i) begin
    pay_q.valid <= 1'b0;
    pay_q.sat   <= (rem0 >= mden);
    pay_q.neg   <= dividend_i[fpd_pkg::WordW-1] ^ divisor_i[fpd_pkg::WordW-1];
    pay_q.rem   <= rem0;
    pay_q.dq    <= num_ext[fpd_pkg::QuotBits-1:0];
    pay_q.den   <= mden;
  end

  always_comb begin
    stage_o       = pay_q;
    stage_o.valid = valid_q;
  end

endmodule

@@ src/fpd_cell.sv @@
// One restoring-division cell: resolves one quotient bit per cycle.
module fpd_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  fpd_pkg::stage_t stage_i,
  output fpd_pkg::stage_t stage_o
);

  logic [fpd_pkg::WordW:0] trial, diff;
  logic                    ge;
  logic                    valid_q;
  fpd_pkg::stage_t         pay_q;

  assign trial = {stage_i.rem, stage_i.dq[fpd_pkg::QuotBits-1]};
  assign diff  = trial - {1'b0, stage_i.den};
  assign ge    = (trial >= {1'b0, stage_i.den});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= stage_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    pay_q.valid <= 1'b0;
    pay_q.sat   <= stage_i.sat;
    pay_q.neg   <= stage_i.neg;
    pay_q.rem   <= ge ? diff[fpd_pkg::WordW-1:0] : trial[fpd_pkg::WordW-1:0];
    pay_q.dq    <= {stage_i.dq[fpd_pkg::QuotBits-2:0], ge};
    pay_q.den   <= stage_i.den;
  end

  always_comb begin
    stage_o       = pay_q;
    stage_o.valid = valid_q;
  end

endmodule

@@ src/fpd_post.sv @@
// Output stage: sign fix-up, saturation select, output register.
module fpd_post (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  fpd_pkg::stage_t                  stage_i,
  output logic                             done_o,
  output logic signed [fpd_pkg::WordW-1:0] quotient_o,
  output logic                             saturated_o
);

  logic [fpd_pkg::WordW-1:0] mag, res_d;
  logic                      done_q;
  logic [fpd_pkg::WordW-1:0] res_q;
  logic                      sat_q;

  assign mag = {{(fpd_pkg::WordW-fpd_pkg::QuotBits){1'b0}}, stage_i.dq};

  always_comb begin
    if (stage_i.sat) begin
      res_d = stage_i.neg ? fpd_pkg::MostNeg : fpd_pkg::MostPos;
    end else if (stage_i.neg) begin
      res_d = ~mag + 1'b1;
    end else begin
      res_d = mag;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= stage_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    sat_q <= stage_i.sat;
  end

  assign done_o      = done_q;
  assign quotient_o  = res_q;
  assign saturated_o = sat_q;

endmodule

@@ src/fixed_point_16_16_divider_core.sv @@
// Top level of the signed 16.16 saturating fixed-point divider.
//
// Usage: pulse start_i with dividend_i and divisor_i; busy_o is always low,
// so a new item is taken in every cycle. Each item's result sits on
// quotient_o / saturated_o for exactly one cycle, flagged by done_o, after
// the item has passed one input stage, thirty division cells and one
// output stage, each registered. Results come out in input order, one per
// item, and the receiver has no way to stall them: sample on done_o.
// The rate of one item per cycle is set by the cell chain: every cell owns
// one quotient bit and passes its partial remainder on at each edge.
// Saturation (|dividend| >> 14 >= |divisor|, zero divisor included) gives
// 0x80000000 when the operand signs differ, 0x7FFFFFFF otherwise, with
// saturated_o high. Otherwise the quotient is truncated toward zero.
module fixed_point_16_16_divider_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  output logic                             busy_o,
  input  logic signed [fpd_pkg::WordW-1:0] dividend_i,
  input  logic signed [fpd_pkg::WordW-1:0] divisor_i,
  output logic                             done_o,
  output logic signed [fpd_pkg::WordW-1:0] quotient_o,
  output logic                             saturated_o
);

  // stage[0] leaves the input stage, stage[k+1] leaves cell k
  fpd_pkg::stage_t stage [0:fpd_pkg::QuotBits];

  // fully pipelined: never refuses an item
  assign busy_o = 1'b0;

  fpd_prep u_prep (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .dividend_i (dividend_i),
    .divisor_i  (divisor_i),
    .stage_o    (stage[0])
  );

  // One cell per quotient bit, MSB first.
  for (genvar k = 0; k < fpd_pkg::QuotBits; k++) begin : g_cell
    fpd_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .stage_i (stage[k]),
      .stage_o (stage[k+1])
    );
  end

  fpd_post u_post (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .stage_i     (stage[fpd_pkg::QuotBits]),
    .done_o      (done_o),
    .quotient_o  (quotient_o),
    .saturated_o (saturated_o)
  );

endmodule

@@ src/fpd_checker.sv @@
// Port-level checker for the divider, bound to the top level.
`include "fixed_point_16_16_divider_core_assert.svh"

module fpd_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             start_i,
  input logic                             busy_o,
  input logic signed [fpd_pkg::WordW-1:0] dividend_i,
  input logic signed [fpd_pkg::WordW-1:0] divisor_i,
  input logic                             done_o,
  input logic signed [fpd_pkg::WordW-1:0] quotient_o,
  input logic                             saturated_o
);

  logic sign_xor;   // operand signs differ
  logic quot_msb;
  logic quot_ext;   // quotient is one of the two clamp values
  logic live_quot;  // unclamped, nonzero result on the ports

  assign sign_xor  = dividend_i[fpd_pkg::WordW-1] ^ divisor_i[fpd_pkg::WordW-1];
  assign quot_msb  = quotient_o[fpd_pkg::WordW-1];
  assign quot_ext  = (quotient_o == fpd_pkg::MostNeg) || (quotient_o == fpd_pkg::MostPos);
  assign live_quot = done_o && !saturated_o && (quotient_o != '0);

  `FPD_ASSERT_IMPL(a_never_busy, 1'b1, !busy_o)
  `FPD_ASSERT_IMPL(a_sat_extreme, done_o && saturated_o, quot_ext)
  `FPD_ASSERT_SEQ(a_fixed_latency, start_i && !busy_o, ##(fpd_pkg::Latency) done_o)
  `FPD_ASSERT_IMPL(a_sign_ok, live_quot, quot_msb == $past(sign_xor, fpd_pkg::Latency))

endmodule

bind fixed_point_16_16_divider_core fpd_checker u_fpd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start_i     (start_i),
  .busy_o      (busy_o),
  .dividend_i  (dividend_i),
  .divisor_i   (divisor_i),
  .done_o      (done_o),
  .quotient_o  (quotient_o),
  .saturated_o (saturated_o)
);

@@ sim/fixed_point_16_16_divider_core_tb.sv @@
// Self-checking testbench for the signed 16.16 saturating fixed-point divider.
`timescale 1ns / 100ps

module fixed_point_16_16_divider_core_tb;

  localparam int unsigned RandomItems = 550;
  localparam int unsigned DrainAt     = 300;  // sender waits for an empty pipe here
  localparam int unsigned SteadyLo    = 150;  // items in [SteadyLo, SteadyHi) go back to back
  localparam int unsigned SteadyHi    = 220;

  // Expected quotient for each division taken in, oldest first.
  class quotient_scoreboard;
    typedef struct packed {
      logic [fpd_pkg::WordW-1:0] quotient;
      logic                      saturated;
    } quot_t;

    quot_t       pending_q[$];
    int unsigned mismatches;

    function new();
      mismatches = 0;
    endfunction

    // Work on magnitudes, clamp if the guard test fires, sign at the end.
    function quot_t expected_quotient(logic [fpd_pkg::WordW-1:0] num,
                                      logic [fpd_pkg::WordW-1:0] den);
      logic [fpd_pkg::WordW-1:0] mnum;
      logic [fpd_pkg::WordW-1:0] mden;
      logic                      neg;
      logic [fpd_pkg::NumW-1:0]  wide;
      quot_t                     res;
      mnum = num[fpd_pkg::WordW-1] ? (~num + 1'b1) : num;
      mden = den[fpd_pkg::WordW-1] ? (~den + 1'b1) : den;
      neg  = num[fpd_pkg::WordW-1] ^ den[fpd_pkg::WordW-1];
      if ((mnum >> fpd_pkg::GuardShift) >= mden) begin
        // zero divisor always lands here
        res.saturated = 1'b1;
        res.quotient  = neg ? fpd_pkg::MostNeg : fpd_pkg::MostPos;
      end else begin
        wide          = {mnum, {fpd_pkg::FracBits{1'b0}}} /
                        {{fpd_pkg::FracBits{1'b0}}, mden};
        res.saturated = 1'b0;
        res.quotient  = neg ? (~wide[fpd_pkg::WordW-1:0] + 1'b1) : wide[fpd_pkg::WordW-1:0];
      end
      return res;
    endfunction

    function void note_division(logic [fpd_pkg::WordW-1:0] num,
                                logic [fpd_pkg::WordW-1:0] den);
      pending_q.push_back(expected_quotient(num, den));
    endfunction

    function void check_quotient(logic [fpd_pkg::WordW-1:0] quotient, logic saturated);
      quot_t exp_q;
      if (pending_q.size() == 0) begin
        $error("unexpected result: quotient %h saturated %b", quotient, saturated);
        mismatches++;
        return;
      end
      exp_q = pending_q.pop_front();
      if (quotient !== exp_q.quotient) begin
        $error("quotient: expected %h, actual %h", exp_q.quotient, quotient);
        mismatches++;
      end
      if (saturated !== exp_q.saturated) begin
        $error("saturated: expected %b, actual %b", exp_q.saturated, saturated);
        mismatches++;
      end
    endfunction

    function int unsigned outstanding();
      return pending_q.size();
    endfunction

    function void check_drained();
      if (pending_q.size() != 0) begin
        $error("%0d results never arrived", pending_q.size());
        mismatches++;
      end
    endfunction
  endclass

  logic                             clk_i;
  logic                             rst_ni;
  logic                             start_i;
  logic                             busy_o;
  logic signed [fpd_pkg::WordW-1:0] dividend_i;
  logic signed [fpd_pkg::WordW-1:0] divisor_i;
  logic                             done_o;
  logic signed [fpd_pkg::WordW-1:0] quotient_o;
  logic                             saturated_o;

  quotient_scoreboard div_sb;

  fixed_point_16_16_divider_core u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .busy_o     (busy_o),
    .dividend_i (dividend_i),
    .divisor_i  (divisor_i),
    .done_o     (done_o),
    .quotient_o (quotient_o),
    .saturated_o(saturated_o)
  );

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  // Monitor: values read at the edge are the ones that edge takes in.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o === 1'b1) div_sb.check_quotient(quotient_o, saturated_o);
      if (start_i === 1'b1 && busy_o === 1'b0) div_sb.note_division(dividend_i, divisor_i);
    end
  end

  // Called right after an edge; returns at the edge that takes the item.
  task automatic send_division(logic [fpd_pkg::WordW-1:0] num,
                               logic [fpd_pkg::WordW-1:0] den);
    start_i    <= 1'b1;
    dividend_i <= num;
    divisor_i  <= den;
    do @(posedge clk_i); while (busy_o !== 1'b0);
  endtask

  task automatic idle_cycles(int unsigned n);
    if (n == 0) return;
    start_i <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  // Mostly back to back, some short gaps, a few long ones.
  function automatic int unsigned gap_length();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  function automatic logic [fpd_pkg::WordW-1:0] random_sign(logic [fpd_pkg::WordW-1:0] mag);
    return $urandom_range(0, 1) ? (~mag + 1'b1) : mag;
  endfunction

  function automatic logic [fpd_pkg::WordW-1:0] pick_extreme();
    case ($urandom_range(0, 4))
      0:       return fpd_pkg::MostNeg;
      1:       return fpd_pkg::MostPos;
      2:       return '0;
      3:       return 32'd1;
      default: return '1;
    endcase
  endfunction

  logic [fpd_pkg::WordW-1:0] dir_num[$];
  logic [fpd_pkg::WordW-1:0] dir_den[$];

  task automatic add_directed(logic [fpd_pkg::WordW-1:0] num,
                              logic [fpd_pkg::WordW-1:0] den);
    dir_num.push_back(num);
    dir_den.push_back(den);
  endtask

  initial begin
    logic [fpd_pkg::WordW-1:0] num;
    logic [fpd_pkg::WordW-1:0] den;
    logic [fpd_pkg::WordW-1:0] lim;
    int unsigned               gap;

    div_sb     = new();
    rst_ni     = 1'b0;
    start_i    = 1'b0;
    dividend_i = '0;
    divisor_i  = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: zero divisor with dividends of both signs, extremes, guard boundary, rounding.
    add_directed(32'h0000_0000, 32'h0000_0000);  // 0/0 clamps positive
    add_directed(32'h0001_0000, 32'h0000_0000);
    add_directed(32'hFFFF_0000, 32'h0000_0000);  // negative / 0 clamps negative
    add_directed(fpd_pkg::MostNeg, 32'h0000_0000);
    add_directed(32'h0000_0000, 32'h0000_0001);
    add_directed(32'h0000_0000, 32'hFFFF_FFFF);
    add_directed(32'h0001_0000, 32'h0001_0000);  // 1.0 / 1.0
    add_directed(32'hFFFC_8000, 32'h0002_0000);  // -3.5 / 2.0
    add_directed(32'hFFFF_FFFF, 32'h0000_0003);  // truncation toward zero
    add_directed(32'h0001_0000, 32'h0000_0004);  // guard test exactly equal
    add_directed(32'h0001_0000, 32'h0000_0005);  // one above the guard
    add_directed(32'h0001_0000, 32'hFFFF_FFFB);
    add_directed(32'hFFFF_0000, 32'h0000_0005);
    add_directed(fpd_pkg::MostNeg, fpd_pkg::MostNeg);
    add_directed(fpd_pkg::MostPos, fpd_pkg::MostPos);
    add_directed(fpd_pkg::MostNeg, fpd_pkg::MostPos);
    add_directed(fpd_pkg::MostPos, fpd_pkg::MostNeg);
    add_directed(32'h0000_0001, fpd_pkg::MostNeg);
    add_directed(fpd_pkg::MostNeg, 32'h0000_0001);
    add_directed(fpd_pkg::MostPos, 32'hFFFF_FFFF);
    add_directed(fpd_pkg::MostNeg, 32'h0002_0000);  // |MIN| >> 14 is exactly 2^17
    add_directed(fpd_pkg::MostNeg, 32'h0002_0001);
    add_directed(fpd_pkg::MostPos, 32'h0002_0000);

    foreach (dir_num[i]) begin
      send_division(dir_num[i], dir_den[i]);
      idle_cycles($urandom_range(0, 2));
    end

    for (int unsigned i = 0; i < RandomItems; i++) begin
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          num = $urandom();
          den = $urandom();
        end
        3, 4, 5: begin
          // divisor magnitude straddling the saturation threshold
          num = $urandom();
          lim = (num[fpd_pkg::WordW-1] ? (~num + 1'b1) : num) >> fpd_pkg::GuardShift;
          den = random_sign(lim + $urandom_range(0, 2) - 1);
        end
        6, 7: begin
          num = random_sign($urandom_range(0, 32'h0010_0000));
          den = random_sign($urandom_range(1, 32'h0008_0000));
        end
        8: begin
          num = $urandom();
          den = random_sign($urandom_range(0, 255));
        end
        default: begin
          num = $urandom_range(0, 1) ? pick_extreme() : $urandom();
          den = $urandom_range(0, 1) ? pick_extreme() : $urandom();
        end
      endcase

      if (i == DrainAt) begin
        // hold off until the pipe has emptied completely
        idle_cycles(1);
        while (div_sb.outstanding() != 0) @(posedge clk_i);
      end

      send_division(num, den);
      gap = (i >= SteadyLo && i < SteadyHi) ? 0 : gap_length();
      idle_cycles(gap);
    end

    start_i <= 1'b0;
    while (div_sb.outstanding() != 0) @(posedge clk_i);
    // stray results would show up within one pipeline depth
    repeat (fpd_pkg::Latency + 8) @(posedge clk_i);
    div_sb.check_drained();

    if (div_sb.mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
